/* sv/matrix4x4_multiply_defines.svh */
// Assertion macros shared by the matrix multiplier RTL.
// Depends on nothing; included by the files that carry checks.
`ifndef MATRIX4X4_MULTIPLY_DEFINES_SVH
`define MATRIX4X4_MULTIPLY_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define MM4_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mm4 check failed");
// Next-cycle implication
`define MM4_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mm4 check failed");
`else
`define MM4_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define MM4_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/mm4_pkg.sv */
// Types and command codes for the matrix multiplier.
// No dependencies; imported by mm4_mac and matrix4x4_multiply.
package mm4_pkg;

    // Command codes of the input item
    localparam logic [1:0] CMD_WR_LEFT  = 2'd0;
    localparam logic [1:0] CMD_WR_RIGHT = 2'd1;
    localparam logic [1:0] CMD_COMPUTE  = 2'd2;

    // Width of the value fields on the ports
    localparam int VAL_W = 32;

    typedef struct packed {
        logic [1:0]              cmd;
        logic [1:0]              row_index;
        logic [1:0]              column_index;
        logic signed [VAL_W-1:0] element_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]              out_row;
        logic [1:0]              out_column;
        logic signed [VAL_W-1:0] product_value;
        logic                    last;
    } t_out_item;

    // Tag that travels with each operand pair into the MAC
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } t_state;

endpackage

/* sv/mm4_mac.sv */
// Multiply-accumulate datapath: one product per cycle, exact sum,
// arithmetic shift and saturation. Depends on mm4_pkg.
module mm4_mac #(
    parameter int DIM        = 4,
    parameter int FRAC_BITS  = 16,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mm4_pkg::t_mac_ctl                    i_ctl,
    input  logic signed [ELEM_WIDTH-1:0]         i_left,
    input  logic signed [ELEM_WIDTH-1:0]         i_right,
    input  logic                                 i_take,
    output logic                                 o_done,
    output logic signed [mm4_pkg::VAL_W-1:0]     o_sum
);
    import mm4_pkg::*;

    localparam int PW = 2 * ELEM_WIDTH;
    localparam int AW = PW + $clog2(DIM);

    t_mac_ctl               r_ctl2;
    logic signed [PW-1:0]   r_prod;
    logic signed [AW-1:0]   r_acc;
    logic                   r_done;
    logic signed [AW-1:0]   w_prod_ext;
    logic signed [AW-1:0]   w_shift;
    logic [AW-ELEM_WIDTH:0] w_top;
    logic                   w_fits;
    logic signed [ELEM_WIDTH-1:0] w_sat;

    // Product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
        end else begin
            r_ctl2 <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_left * i_right;
    end

    assign w_prod_ext = AW'(r_prod);

    // Accumulate stage; first term of an element restarts the sum
    always_ff @(posedge i_clk) begin
        if (r_ctl2.valid) begin
            r_acc <= r_ctl2.first ? w_prod_ext : r_acc + w_prod_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else if (r_ctl2.valid && r_ctl2.last) begin
            r_done <= 1'b1;
        end else if (i_take) begin
            r_done <= 1'b0;
        end
    end

    // Shift down (floor) and clamp to the element range
    assign w_shift = r_acc >>> FRAC_BITS;
    assign w_top   = w_shift[AW-1:ELEM_WIDTH-1];
    assign w_fits  = (&w_top) || !(|w_top);

    always_comb begin
        if (w_fits) begin
            w_sat = w_shift[ELEM_WIDTH-1:0];
        end else if (w_shift[AW-1]) begin
            w_sat = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
        end
    end

    assign o_done = r_done;
    assign o_sum  = VAL_W'(w_sat);

endmodule

/* sv/matrix4x4_multiply.sv */
// Fixed-point DIM x DIM matrix multiplier. Write items (cmd 0 left, cmd 1 right) are taken
// one per cycle and store one element each; writes outside the matrix and cmd 3 do nothing.
// A compute item (cmd 2) emits the DIM*DIM product elements in row-major order, the last
// one flagged; input ready stays low until the final product is in the output register.
// Each product element is formed by DIM reads from each operand memory, then the multiply and
// accumulate stages drain; the next element starts only after this one is loaded, and an
// output stall holds it. Each operand memory has a single read port and one multiplier is
// shared by all elements. Both memories read as zero after reset until written.
`include "matrix4x4_multiply_defines.svh"
module matrix4x4_multiply #(
    parameter int DIM        = 4,
    parameter int FRAC_BITS  = 16,
    parameter int ELEM_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mm4_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mm4_pkg::t_out_item o_out_item
);
    import mm4_pkg::*;

    localparam int CELLS = DIM * DIM;
    localparam int IW    = $clog2(DIM);
    localparam int CW    = $clog2(CELLS);
    localparam logic [IW-1:0] IDX_LAST = IW'(DIM - 1);

    t_state                 r_state, n_state;
    logic [IW-1:0]          r_r, n_r, r_c, n_c, r_k, n_k;
    logic                   w_in_acc, w_issue, w_load, w_last_elem;
    logic                   w_wr_ok, w_wr_left, w_wr_right;
    logic [CW-1:0]          w_wr_addr, w_left_addr, w_right_addr;

    // Operand memories and their valid bits
    logic [ELEM_WIDTH-1:0]  r_left_mem  [CELLS];
    logic [ELEM_WIDTH-1:0]  r_right_mem [CELLS];
    logic [CELLS-1:0]       r_left_vld, r_right_vld;
    logic [ELEM_WIDTH-1:0]  r_left_rd, r_right_rd;
    logic                   r_left_ok, r_right_ok;
    t_mac_ctl               r_ctl1, w_ctl0;
    logic signed [ELEM_WIDTH-1:0] w_left_op, w_right_op;

    logic                      w_mac_done;
    logic signed [VAL_W-1:0]   w_mac_sum;
    logic                      r_out_valid;
    t_out_item                 r_out_item;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;

    // Write decode
    assign w_wr_ok    = (32'(i_in_item.row_index) < DIM) && (32'(i_in_item.column_index) < DIM);
    assign w_wr_addr  = CW'(32'(i_in_item.row_index) * DIM + 32'(i_in_item.column_index));
    assign w_wr_left  = w_in_acc && w_wr_ok && (i_in_item.cmd == CMD_WR_LEFT);
    assign w_wr_right = w_in_acc && w_wr_ok && (i_in_item.cmd == CMD_WR_RIGHT);

    // Read addresses: left row r, right column c, term k
    assign w_left_addr  = CW'(32'(r_r) * DIM + 32'(r_k));
    assign w_right_addr = CW'(32'(r_k) * DIM + 32'(r_c));
    assign w_last_elem  = (r_r == IDX_LAST) && (r_c == IDX_LAST);

    // Sequencer: next state and control
    always_comb begin
        n_state = r_state;
        n_r     = r_r;
        n_c     = r_c;
        n_k     = r_k;
        w_issue = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_in_item.cmd == CMD_COMPUTE)) begin
                    n_state = S_RUN;
                    n_r     = '0;
                    n_c     = '0;
                    n_k     = '0;
                end
            end
            S_RUN: begin
                w_issue = 1'b1;
                if (r_k == IDX_LAST) begin
                    n_state = S_HOLD;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_HOLD: begin
                if (w_mac_done && (!r_out_valid || i_out_ready)) begin
                    w_load = 1'b1;
                    n_k    = '0;
                    if (w_last_elem) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_RUN;
                        if (r_c == IDX_LAST) begin
                            n_c = '0;
                            n_r = r_r + 1'b1;
                        end else begin
                            n_c = r_c + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_r     <= '0;
            r_c     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_r     <= n_r;
            r_c     <= n_c;
            r_k     <= n_k;
        end
    end

    // Memory writes
    always_ff @(posedge i_clk) begin
        if (w_wr_left) begin
            r_left_mem[w_wr_addr] <= i_in_item.element_value[ELEM_WIDTH-1:0];
        end
        if (w_wr_right) begin
            r_right_mem[w_wr_addr] <= i_in_item.element_value[ELEM_WIDTH-1:0];
        end
    end

    // Memory reads, registered
    always_ff @(posedge i_clk) begin
        r_left_rd  <= r_left_mem[w_left_addr];
        r_right_rd <= r_right_mem[w_right_addr];
    end

    // Valid bits: an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_vld  <= '0;
            r_right_vld <= '0;
            r_left_ok   <= 1'b0;
            r_right_ok  <= 1'b0;
        end else begin
            if (w_wr_left) begin
                r_left_vld[w_wr_addr] <= 1'b1;
            end
            if (w_wr_right) begin
                r_right_vld[w_wr_addr] <= 1'b1;
            end
            r_left_ok  <= r_left_vld[w_left_addr];
            r_right_ok <= r_right_vld[w_right_addr];
        end
    end

    // Tag aligned with the read data
    assign w_ctl0 = '{valid: w_issue, first: (r_k == '0), last: (r_k == IDX_LAST)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
        end else begin
            r_ctl1 <= w_ctl0;
        end
    end

    assign w_left_op  = r_left_ok  ? r_left_rd  : '0;
    assign w_right_op = r_right_ok ? r_right_rd : '0;

    mm4_mac #(
        .DIM        (DIM),
        .FRAC_BITS  (FRAC_BITS),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_ctl1),
        .i_left  (w_left_op),
        .i_right (w_right_op),
        .i_take  (w_load),
        .o_done  (w_mac_done),
        .o_sum   (w_mac_sum)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_item.out_row       <= 2'(r_r);
            r_out_item.out_column    <= 2'(r_c);
            r_out_item.product_value <= w_mac_sum;
            r_out_item.last          <= w_last_elem;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Checks
    `MM4_ASSERT_SAME(a_idle_no_pending, i_clk, i_rst_n, r_state == S_IDLE, !w_mac_done)
    `MM4_ASSERT_NEXT(a_run_issues, i_clk, i_rst_n, r_state == S_RUN, r_ctl1.valid)
    `MM4_ASSERT_NEXT(a_last_to_idle, i_clk, i_rst_n, w_load && w_last_elem, r_state == S_IDLE)
    `MM4_ASSERT_NEXT(a_compute_start, i_clk, i_rst_n,
        w_in_acc && (i_in_item.cmd == CMD_COMPUTE),
        (r_state == S_RUN) && (r_r == '0) && (r_c == '0) && (r_k == '0))
    `MM4_ASSERT_SAME(a_load_needs_room, i_clk, i_rst_n, w_load, !r_out_valid || i_out_ready)

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the 4x4 signed Q16.16 matrix multiplier.
// Depends on mm4_pkg and matrix4x4_multiply; carries its own model of the two element stores.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mm4_pkg::*;

    localparam int MATRIX_DIM   = 4;
    localparam int CELL_COUNT   = MATRIX_DIM * MATRIX_DIM;
    localparam int FRAC_SHIFT   = 16;
    localparam int CLK_PERIOD   = 12;
    localparam int RANDOM_ITEMS = 140;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 500000;

    // cmd 3 has no meaning in the block
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic signed [65:0] SUM_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SUM_MIN = -66'sd2147483648;
    localparam logic signed [31:0] ELEM_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] ELEM_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_in_item   i_in_item = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_item  o_out_item;

    // Model state: operand stores and products still to arrive
    logic signed [31:0] left_elems [CELL_COUNT];
    logic signed [31:0] right_elems [CELL_COUNT];
    t_out_item          pending_products[$];
    int unsigned        error_count = 0;
    int unsigned        cycle_count = 0;
    int unsigned        burst_left = 0;

    matrix4x4_multiply #(
        .DIM       (MATRIX_DIM),
        .FRAC_BITS (FRAC_SHIFT),
        .ELEM_WIDTH(32)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Exact four-term dot product, floor shift, saturate to 32 bits
    function automatic logic signed [31:0] product_at(input int r, input int c);
        logic signed [65:0] sum_wide;
        logic signed [65:0] shifted;
        longint             lhs;
        longint             rhs;
        longint             term;
        sum_wide = '0;
        for (int k = 0; k < MATRIX_DIM; k++) begin
            lhs = left_elems[r * MATRIX_DIM + k];
            rhs = right_elems[k * MATRIX_DIM + c];
            term = lhs * rhs;
            sum_wide += term;
        end
        shifted = sum_wide >>> FRAC_SHIFT;
        if (shifted > SUM_MAX) begin
            return ELEM_MAX;
        end else if (shifted < SUM_MIN) begin
            return ELEM_MIN;
        end
        return shifted[31:0];
    endfunction

    // Update the stores for one accepted item, queue any products it causes
    function automatic void apply_item(input t_in_item item);
        t_out_item prod;
        int        cell_idx;
        cell_idx = item.row_index * MATRIX_DIM + item.column_index;
        case (item.cmd)
            CMD_WR_LEFT: begin
                left_elems[cell_idx] = item.element_value;
            end
            CMD_WR_RIGHT: begin
                right_elems[cell_idx] = item.element_value;
            end
            CMD_COMPUTE: begin
                for (int r = 0; r < MATRIX_DIM; r++) begin
                    for (int c = 0; c < MATRIX_DIM; c++) begin
                        prod.out_row       = 2'(r);
                        prod.out_column    = 2'(c);
                        prod.product_value = product_at(r, c);
                        prod.last          = (r == MATRIX_DIM - 1) && (c == MATRIX_DIM - 1);
                        pending_products.push_back(prod);
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic t_in_item make_item(input logic [1:0] cmd, input int row, input int col,
                                           input logic [31:0] value);
        t_in_item item;
        item.cmd           = cmd;
        item.row_index     = 2'(row);
        item.column_index  = 2'(col);
        item.element_value = value;
        return item;
    endfunction

    // Element values: extremes, small Q16.16 numbers that stay in range, raw random words
    function automatic logic [31:0] pick_value();
        logic [31:0] mag;
        case ($urandom_range(0, 9))
            0: return ELEM_MAX;
            1: return ELEM_MIN;
            2: return '0;
            3, 4, 5: begin
                mag = $urandom_range(0, 4 << FRAC_SHIFT);
                return $urandom_range(0, 1) ? -mag : mag;
            end
            default: return $urandom();
        endcase
    endfunction

    // Sender works in bursts; between bursts it drops valid for a random gap
    task automatic sender_pause();
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Present one item and hold it until the block takes it
    task automatic send_item(input t_in_item item);
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        apply_item(item);
        sender_pause();
    endtask

    task automatic send_compute();
        send_item(make_item(CMD_COMPUTE, $urandom_range(0, 3), $urandom_range(0, 3),
                            $urandom()));
    endtask

    // Stores are zero after reset, so the first product is all zero
    task automatic test_reset_contents();
        send_compute();
    endtask

    // Saturation both ways, exact values, and floor rounding of a tiny negative sum
    task automatic test_saturation();
        send_item(make_item(CMD_WR_LEFT, 0, 0, ELEM_MAX));
        send_item(make_item(CMD_WR_LEFT, 1, 0, ELEM_MIN));
        send_item(make_item(CMD_WR_LEFT, 2, 0, ELEM_MIN));
        send_item(make_item(CMD_WR_RIGHT, 0, 0, ELEM_MAX));
        send_item(make_item(CMD_WR_RIGHT, 0, 1, ELEM_MIN));
        send_item(make_item(CMD_WR_LEFT, 3, 0, Q_ONE));
        send_item(make_item(CMD_WR_RIGHT, 0, 2, 32'hFFFF_8000));
        send_item(make_item(CMD_WR_LEFT, 3, 1, 32'h0000_0001));
        send_item(make_item(CMD_WR_RIGHT, 1, 3, 32'hFFFF_FFFF));
        send_item(make_item(CMD_WR_RIGHT, 3, 3, 32'h5555_5555));
        send_item(make_item(CMD_WR_LEFT, 2, 3, 32'hAAAA_AAAA));
        send_compute();
    endtask

    // cmd 3 writes nothing; compute ignores its fields and keeps both operands
    task automatic test_ignored_fields();
        send_item(make_item(CMD_UNUSED, 0, 0, ELEM_MAX));
        send_item(make_item(CMD_UNUSED, 3, 3, 32'hFFFF_FFFF));
        send_item(make_item(CMD_COMPUTE, 3, 3, 32'hFFFF_FFFF));
        send_item(make_item(CMD_COMPUTE, 0, 0, '0));
        send_item(make_item(CMD_WR_RIGHT, 3, 0, Q_ONE));
        send_compute();
    endtask

    // Mostly load-then-compute sequences; some stray commands and bare computes
    task automatic test_random_sequences();
        int sent;
        int writes;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: begin
                    send_item(make_item(CMD_UNUSED, $urandom_range(0, 3),
                                        $urandom_range(0, 3), $urandom()));
                end
                1: begin
                    send_compute();
                    sent++;
                end
                default: begin
                    writes = $urandom_range(1, 16);
                    repeat (writes) begin
                        send_item(make_item($urandom_range(0, 1) ? CMD_WR_RIGHT : CMD_WR_LEFT,
                                            $urandom_range(0, 3), $urandom_range(0, 3),
                                            pick_value()));
                    end
                    send_compute();
                    sent += writes + 1;
                end
            endcase
        end
    endtask

    // Receiver ready follows a rotating pattern, reloaded now and then
    logic [7:0]  ready_pattern = 8'hFF;
    int unsigned ready_tick = 0;
    always @(posedge i_clk) begin
        ready_tick <= ready_tick + 1;
        if (ready_tick % 48 == 47) begin
            ready_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
        end else begin
            ready_pattern <= {ready_pattern[6:0], ready_pattern[7]};
        end
        i_out_ready <= ready_pattern[0];
    end

    // Compare each accepted product item with the oldest expected one
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_products.size() == 0) begin
                $display("%0t: unexpected product item row %0d col %0d value %0d last %0b",
                         $time, o_out_item.out_row, o_out_item.out_column,
                         o_out_item.product_value, o_out_item.last);
                error_count++;
            end else begin
                want = pending_products.pop_front();
                if (o_out_item.out_row !== want.out_row) begin
                    $display("%0t: out_row expected %0d got %0d", $time,
                             want.out_row, o_out_item.out_row);
                    error_count++;
                end
                if (o_out_item.out_column !== want.out_column) begin
                    $display("%0t: out_column expected %0d got %0d", $time,
                             want.out_column, o_out_item.out_column);
                    error_count++;
                end
                if (o_out_item.product_value !== want.product_value) begin
                    $display("%0t: product_value (%0d,%0d) expected %0d got %0d", $time,
                             want.out_row, want.out_column, want.product_value,
                             o_out_item.product_value);
                    error_count++;
                end
                if (o_out_item.last !== want.last) begin
                    $display("%0t: last (%0d,%0d) expected %0b got %0b", $time,
                             want.out_row, want.out_column, want.last, o_out_item.last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[matrix4x4_multiply] ERROR");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < CELL_COUNT; i++) begin
            left_elems[i]  = '0;
            right_elems[i] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_contents();
        test_saturation();
        test_ignored_fields();
        test_random_sequences();
        i_in_valid <= 1'b0;

        // Drain outstanding products, then watch for strays
        while (pending_products.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[matrix4x4_multiply] OK");
        end else begin
            $display("[matrix4x4_multiply] ERROR");
        end
        $finish;
    end

endmodule
